@@ src/i4gq_pkg.sv @@
package i4gq_pkg;

  localparam int unsigned ACC_LANES = 8;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] FP32_ONE = 32'h3F80_0000;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

  localparam logic [3:0] STEP_ITEM_END = 4'd7;
  localparam logic [3:0] STEP_LAST = 4'd14;

  localparam logic [2:0] RED_LEFT = 3'd4;
  localparam logic [2:0] RED_RIGHT = 3'd5;
  localparam logic [2:0] RED_FINAL = 3'd6;

  typedef enum logic [1:0] {
    OP_DEQ,
    OP_ACC,
    OP_RED
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       issue;
    op_e        op;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic last;
    logic out_full;
  } stat_t;

  function automatic logic [31:0] fp16_to_f32(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  pos;
    logic [9:0]  norm;
    logic [7:0]  e32;
    logic [31:0] r;
    ex = h[14:10];
    man = h[9:0];
    pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) pos = 4'(i);
    end
    norm = man << (4'd10 - pos);
    e32 = 8'd103 + {4'b0, pos};
    if (ex == 5'd0) begin
      if (man == 10'd0) r = {h[15], 31'b0};
      else r = {h[15], e32, norm, 13'b0};
    end else if (ex == 5'd31) begin
      r = {h[15], 8'hFF, man, 13'b0};
    end else begin
      r = {h[15], 8'({3'b0, ex} + 8'd112), man, 13'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] nib_to_f32(input logic [3:0] q);
    logic [1:0]  pos;
    logic [23:0] m;
    logic [31:0] r;
    pos = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (q[i]) pos = 2'(i);
    end
    m = {q, 20'b0} << (2'd3 - pos);
    if (q == 4'd0) r = 32'd0;
    else r = {1'b0, 8'd127 + {6'b0, pos}, m[22:0]};
    return r;
  endfunction

endpackage

@@ src/i4gq_in_if.sv @@
interface i4gq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] act_a;
  logic [31:0] act_b;
  logic [31:0] act_c;
  logic [31:0] act_d;
  logic [15:0] weight_nibbles;
  logic [15:0] group_scale;
  logic [15:0] group_zero;
  logic        last;

  modport source (
    output valid, act_a, act_b, act_c, act_d, weight_nibbles, group_scale, group_zero, last,
    input  ready
  );
  modport sink (
    input  valid, act_a, act_b, act_c, act_d, weight_nibbles, group_scale, group_zero, last,
    output ready
  );
endinterface

@@ src/i4gq_out_if.sv @@
interface i4gq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_sum;

  modport source (output valid, dot_sum, input ready);
  modport sink (input valid, dot_sum, output ready);
endinterface

@@ src/int4_group_quant_dot_product.sv @@
// Group-quantized 4-bit weight dot product with fp32 lane accumulators.
// in_i carries one item per transfer: four fp32 activations, four packed
// unsigned 4-bit weights and the fp16 scale and zero of the group. Each
// weight is dequantized (q*scale-zero, fused) and fused-multiply-added
// into one of eight lanes; even items use lanes 0-3, odd items 4-7.
// An item with last set is followed by the lane reduction, and out_o
// carries one fp32 dot_sum transfer per vector.
// All arithmetic runs through one pipelined fp32 fused multiply-add,
// issued one operation at a time. An item takes eight operations
// from transfer until in_i.ready rises again; a last item adds the
// seven reduction adds, and dot_sum is valid in the cycle after the
// last of them completes.
// Reset clears all lanes to +0.0, selects lanes 0-3 and empties out_o.
// A result waiting on out_o does not block new items; only the final
// reduction add of the next vector holds until that result is taken.
module int4_group_quant_dot_product (
  input  logic        clk_i,
  input  logic        rst_ni,
  i4gq_in_if.sink     in_i,
  i4gq_out_if.source  out_o
);

  i4gq_pkg::cmd_t  cmd;
  i4gq_pkg::stat_t stat;
  logic            ready;

  i4gq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  i4gq_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .act_a_i          (in_i.act_a),
    .act_b_i          (in_i.act_b),
    .act_c_i          (in_i.act_c),
    .act_d_i          (in_i.act_d),
    .weight_nibbles_i (in_i.weight_nibbles),
    .group_scale_i    (in_i.group_scale),
    .group_zero_i     (in_i.group_zero),
    .last_i           (in_i.last),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .dot_sum_o        (out_o.dot_sum)
  );

  assign in_i.ready = ready;

endmodule

@@ src/i4gq_fma.sv @@
module i4gq_fma (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  logic [5:0] v_q;

  logic [7:0]  ea, eb, ec, eaa, eab, eac;
  logic [23:0] ma, mb, mc;
  logic        nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zero_a, zero_b, zero_c;
  logic        sp, byp_d;
  logic [31:0] bval_d;

  logic [47:0]        prod_q;
  logic [23:0]        mc_q;
  logic               sp1_q, sc1_q;
  logic signed [11:0] d_q, e0n_q, e0c_q;
  logic               byp_q [5];
  logic [31:0]        bval_q [5];

  assign ea = a_i[30:23];
  assign eb = b_i[30:23];
  assign ec = c_i[30:23];
  assign ma = {|ea, a_i[22:0]};
  assign mb = {|eb, b_i[22:0]};
  assign mc = {|ec, c_i[22:0]};
  assign eaa = (ea == 8'd0) ? 8'd1 : ea;
  assign eab = (eb == 8'd0) ? 8'd1 : eb;
  assign eac = (ec == 8'd0) ? 8'd1 : ec;
  assign nan_a = (ea == 8'hFF) && (a_i[22:0] != 23'd0);
  assign nan_b = (eb == 8'hFF) && (b_i[22:0] != 23'd0);
  assign nan_c = (ec == 8'hFF) && (c_i[22:0] != 23'd0);
  assign inf_a = (ea == 8'hFF) && (a_i[22:0] == 23'd0);
  assign inf_b = (eb == 8'hFF) && (b_i[22:0] == 23'd0);
  assign inf_c = (ec == 8'hFF) && (c_i[22:0] == 23'd0);
  assign zero_a = (a_i[30:0] == 31'd0);
  assign zero_b = (b_i[30:0] == 31'd0);
  assign zero_c = (c_i[30:0] == 31'd0);
  assign sp = a_i[31] ^ b_i[31];

  always_comb begin
    byp_d = 1'b1;
    bval_d = c_i;
    if (nan_a || nan_b || nan_c || (inf_a && zero_b) || (zero_a && inf_b) ||
        ((inf_a || inf_b) && inf_c && (sp != c_i[31]))) begin
      bval_d = i4gq_pkg::QNAN_BITS;
    end else if (inf_a || inf_b) begin
      bval_d = {sp, 8'hFF, 23'd0};
    end else if (inf_c) begin
      bval_d = c_i;
    end else if (zero_a || zero_b) begin
      bval_d = zero_c ? {sp & c_i[31], 31'd0} : c_i;
    end else begin
      byp_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {24'd0, ma} * {24'd0, mb};
    mc_q <= mc;
    sp1_q <= sp;
    sc1_q <= c_i[31];
    d_q <= $signed({4'd0, eac}) - $signed({4'd0, eaa}) - $signed({4'd0, eab}) + 12'sd176;
    e0n_q <= $signed({4'd0, eaa}) + $signed({4'd0, eab}) - 12'sd326;
    e0c_q <= $signed({4'd0, eac}) - 12'sd226;
    byp_q[0] <= byp_d;
    bval_q[0] <= bval_d;
    for (int i = 1; i < 5; i++) begin
      byp_q[i] <= byp_q[i-1];
      bval_q[i] <= bval_q[i-1];
    end
  end

  logic               clamp;
  logic signed [11:0] sh_full;
  logic [6:0]         shamt;
  logic [123:0]       cwide;
  logic [99:0]        fp_d, fc_d;
  logic [99:0]        fp_q, fc_q;
  logic               sp2_q, sc2_q;
  logic signed [11:0] e02_q;

  always_comb begin
    clamp = d_q > 12'sd76;
    sh_full = 12'sd100 - d_q;
    if (clamp) shamt = 7'd24;
    else if (sh_full > 12'sd124) shamt = 7'd124;
    else shamt = sh_full[6:0];
    cwide = 124'({mc_q, 124'd0} >> shamt);
    fc_d = {cwide[123:25], |cwide[24:0]};
    fp_d = clamp ? 100'd1 : {26'd0, prod_q, 26'd0};
  end

  always_ff @(posedge clk_i) begin
    fp_q <= fp_d;
    fc_q <= fc_d;
    sp2_q <= sp1_q;
    sc2_q <= sc1_q;
    e02_q <= clamp ? e0c_q : e0n_q;
  end

  logic [100:0]       sum_d, diff_d, mag_d;
  logic               sgn_d;
  logic [100:0]       mag_q;
  logic               sgn3_q, zero3_q;
  logic signed [11:0] e03_q;

  always_comb begin
    sum_d = {1'b0, fp_q} + {1'b0, fc_q};
    diff_d = {1'b0, fp_q} - {1'b0, fc_q};
    if (sp2_q == sc2_q) begin
      mag_d = sum_d;
      sgn_d = sp2_q;
    end else if (diff_d[100]) begin
      mag_d = -diff_d;
      sgn_d = sc2_q;
    end else begin
      mag_d = diff_d;
      sgn_d = sp2_q;
    end
    if (mag_d == 101'd0) sgn_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    sgn3_q <= sgn_d;
    zero3_q <= (mag_d == 101'd0);
    e03_q <= e02_q;
  end

  logic [6:0]         pos_d;
  logic [100:0]       mag4_q;
  logic [6:0]         lz4_q;
  logic signed [11:0] ex4_q;
  logic               sgn4_q, zero4_q;

  always_comb begin
    pos_d = 7'd0;
    for (int i = 0; i < 101; i++) begin
      if (mag_q[i]) pos_d = 7'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    mag4_q <= mag_q;
    lz4_q <= 7'd100 - pos_d;
    ex4_q <= 12'sd127 + $signed({5'd0, pos_d}) + e03_q;
    sgn4_q <= sgn3_q;
    zero4_q <= zero3_q;
  end

  logic signed [11:0] rs_full;
  logic [100:0]       t5_q;
  logic [6:0]         rs5_q;
  logic signed [11:0] ex5_q;
  logic               sgn5_q, zero5_q;

  assign rs_full = 12'sd1 - ex4_q;

  always_ff @(posedge clk_i) begin
    t5_q <= mag4_q << lz4_q;
    if (ex4_q > 12'sd0) rs5_q <= 7'd0;
    else if (rs_full > 12'sd101) rs5_q <= 7'd101;
    else rs5_q <= rs_full[6:0];
    ex5_q <= ex4_q;
    sgn5_q <= sgn4_q;
    zero5_q <= zero4_q;
  end

  logic [201:0] w6;
  logic [23:0]  mant;
  logic         guard, sticky, rnd;
  logic [7:0]   ef;
  logic [30:0]  packed_d;
  logic [31:0]  res_d;
  logic [31:0]  res_q;

  always_comb begin
    w6 = {t5_q, 101'd0} >> rs5_q;
    mant = w6[201:178];
    guard = w6[177];
    sticky = |w6[176:0];
    rnd = guard & (sticky | mant[0]);
    ef = (ex5_q > 12'sd0) ? ex5_q[7:0] : 8'd0;
    packed_d = {ef, mant[22:0]} + {30'd0, rnd};
    if (byp_q[4]) res_d = bval_q[4];
    else if (zero5_q) res_d = {sgn5_q, 31'd0};
    else if (ex5_q > 12'sd254) res_d = {sgn5_q, 8'hFF, 23'd0};
    else res_d = {sgn5_q, packed_d};
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 6'd0;
    end else begin
      v_q <= {v_q[4:0], start_i};
    end
  end

  assign done_o = v_q[5];
  assign res_o = res_q;

endmodule

@@ src/i4gq_dp.sv @@
module i4gq_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i4gq_pkg::cmd_t       cmd_i,
  output i4gq_pkg::stat_t      stat_o,
  input  logic [31:0]          act_a_i,
  input  logic [31:0]          act_b_i,
  input  logic [31:0]          act_c_i,
  input  logic [31:0]          act_d_i,
  input  logic [15:0]          weight_nibbles_i,
  input  logic [15:0]          group_scale_i,
  input  logic [15:0]          group_zero_i,
  input  logic                 last_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [31:0]          dot_sum_o
);

  logic [31:0] act_q [4];
  logic [15:0] w_q;
  logic [31:0] scale_q, negz_q, dq_q;
  logic        last_q;
  logic [31:0] lane_q [i4gq_pkg::ACC_LANES];
  logic        half_q;
  i4gq_pkg::op_e dst_op_q;
  logic [2:0]  dst_idx_q;
  logic        out_valid_q;
  logic [31:0] dot_sum_q;

  logic [1:0]  k;
  logic [15:0] w_sh;
  logic [31:0] opa, opb, opc, res;
  logic        done;

  assign k = cmd_i.idx[1:0];
  assign w_sh = w_q >> {k, 2'b00};

  always_comb begin
    opa = act_q[k];
    opb = i4gq_pkg::FP32_ONE;
    opc = lane_q[{half_q, k}];
    case (cmd_i.op)
      i4gq_pkg::OP_DEQ: begin
        opa = i4gq_pkg::nib_to_f32(w_sh[3:0]);
        opb = scale_q;
        opc = negz_q;
      end
      i4gq_pkg::OP_ACC: begin
        opa = act_q[k];
        opb = dq_q;
        opc = lane_q[{half_q, k}];
      end
      i4gq_pkg::OP_RED: begin
        case (cmd_i.idx)
          i4gq_pkg::RED_LEFT: begin
            opa = lane_q[0];
            opc = lane_q[2];
          end
          i4gq_pkg::RED_RIGHT: begin
            opa = lane_q[1];
            opc = lane_q[3];
          end
          i4gq_pkg::RED_FINAL: begin
            opa = lane_q[0];
            opc = lane_q[1];
          end
          default: begin
            opa = lane_q[{1'b0, k}];
            opc = lane_q[{1'b1, k}];
          end
        endcase
      end
      default: ;
    endcase
  end

  i4gq_fma u_fma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.issue),
    .a_i     (opa),
    .b_i     (opb),
    .c_i     (opc),
    .done_o  (done),
    .res_o   (res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q[0] <= act_a_i;
      act_q[1] <= act_b_i;
      act_q[2] <= act_c_i;
      act_q[3] <= act_d_i;
      w_q <= weight_nibbles_i;
      scale_q <= i4gq_pkg::fp16_to_f32(group_scale_i);
      negz_q <= i4gq_pkg::fp16_to_f32(group_zero_i) ^ i4gq_pkg::SIGN_MASK;
      last_q <= last_i;
    end
    if (cmd_i.issue) begin
      dst_op_q <= cmd_i.op;
      dst_idx_q <= cmd_i.idx;
    end
    if (done && (dst_op_q == i4gq_pkg::OP_DEQ)) begin
      dq_q <= res;
    end
    if (done && (dst_op_q == i4gq_pkg::OP_RED) && (dst_idx_q == i4gq_pkg::RED_FINAL)) begin
      dot_sum_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < i4gq_pkg::ACC_LANES; i++) lane_q[i] <= 32'd0;
      half_q <= 1'b0;
    end else if (done) begin
      case (dst_op_q)
        i4gq_pkg::OP_ACC: begin
          lane_q[{half_q, dst_idx_q[1:0]}] <= res;
          if (dst_idx_q[1:0] == 2'd3) half_q <= ~half_q;
        end
        i4gq_pkg::OP_RED: begin
          case (dst_idx_q)
            i4gq_pkg::RED_LEFT: lane_q[0] <= res;
            i4gq_pkg::RED_RIGHT: lane_q[1] <= res;
            i4gq_pkg::RED_FINAL: begin
              for (int i = 0; i < i4gq_pkg::ACC_LANES; i++) lane_q[i] <= 32'd0;
              half_q <= 1'b0;
            end
            default: lane_q[{1'b0, dst_idx_q[1:0]}] <= res;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done && (dst_op_q == i4gq_pkg::OP_RED) &&
                 (dst_idx_q == i4gq_pkg::RED_FINAL)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dot_sum_o = dot_sum_q;
  assign stat_o.done = done;
  assign stat_o.last = last_q;
  assign stat_o.out_full = out_valid_q & ~out_ready_i;

endmodule

@@ src/i4gq_ctrl.sv @@
module i4gq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  i4gq_pkg::stat_t  stat_i,
  output i4gq_pkg::cmd_t   cmd_o
);

  i4gq_pkg::state_e state_q, state_d;
  logic [3:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i4gq_pkg::ST_IDLE;
      step_q <= 4'd0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    in_ready_o = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.issue = 1'b0;
    if (step_q > i4gq_pkg::STEP_ITEM_END) begin
      cmd_o.op = i4gq_pkg::OP_RED;
      cmd_o.idx = step_q[2:0];
    end else begin
      cmd_o.op = step_q[0] ? i4gq_pkg::OP_ACC : i4gq_pkg::OP_DEQ;
      cmd_o.idx = {1'b0, step_q[2:1]};
    end
    case (state_q)
      i4gq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d = 4'd0;
          state_d = i4gq_pkg::ST_ISSUE;
        end
      end
      i4gq_pkg::ST_ISSUE: begin
        if (!((step_q == i4gq_pkg::STEP_LAST) && stat_i.out_full)) begin
          cmd_o.issue = 1'b1;
          state_d = i4gq_pkg::ST_WAIT;
        end
      end
      i4gq_pkg::ST_WAIT: begin
        if (stat_i.done) begin
          if (((step_q == i4gq_pkg::STEP_ITEM_END) && !stat_i.last) ||
              (step_q == i4gq_pkg::STEP_LAST)) begin
            state_d = i4gq_pkg::ST_IDLE;
          end else begin
            step_d = step_q + 4'd1;
            state_d = i4gq_pkg::ST_ISSUE;
          end
        end
      end
      default: state_d = i4gq_pkg::ST_IDLE;
    endcase
  end

endmodule
